// ===== design/stdpw_pkg.sv =====
// Package for the STDP synapse weight updater: beat structs, state enum,
// register indexes and request codes. No dependencies.
package stdpw_pkg;

    typedef struct packed {
        logic        req_type;
        logic        spike_side;
        logic [5:0]  neuron_index;
        logic [5:0]  hidden_read_index;
        logic [31:0] event_time;
        logic [1:0]  learn_phase;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  updated_count;
        logic [15:0] plus_weight;
        logic [15:0] minus_weight;
    } t_out_beat;

    typedef struct packed {
        logic [15:0] ceiling;
        logic [15:0] floor;
    } t_limits;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_FETCH,
        S_EVAL,
        S_UPD_P,
        S_UPD_M,
        S_DONE
    } t_state;

    localparam logic REQ_SPIKE    = 1'b0;
    localparam logic REQ_READ     = 1'b1;
    localparam logic SIDE_VISIBLE = 1'b0;
    localparam logic SIDE_HIDDEN  = 1'b1;
    localparam logic MODE_BIPOLAR = 1'b0;
    localparam logic MODE_DIFF    = 1'b1;

    localparam logic [1:0] PH_DATA  = 2'd0;
    localparam logic [1:0] PH_MODEL = 2'd1;

    localparam logic [2:0] REG_LEARN_MODE     = 3'd0;
    localparam logic [2:0] REG_SET_STEP       = 3'd1;
    localparam logic [2:0] REG_RESET_STEP     = 3'd2;
    localparam logic [2:0] REG_WEIGHT_CEILING = 3'd3;
    localparam logic [2:0] REG_WEIGHT_FLOOR   = 3'd4;
    localparam logic [2:0] REG_SET_WINDOW     = 3'd5;
    localparam logic [2:0] REG_RESET_WINDOW   = 3'd6;
    localparam logic [2:0] REG_STDP_WINDOW    = 3'd7;

endpackage

// ===== design/stdpw_pulse.sv =====
// Shared conductance pulse unit: adds a signed step and clamps to the limits.
// Depends on stdpw_pkg.
module stdpw_pulse (
    input  logic [15:0]        i_weight,
    input  logic signed [16:0] i_step,
    input  stdpw_pkg::t_limits i_lim,
    output logic [15:0]        o_weight
);

    logic signed [17:0] sum;

    assign sum = $signed({2'b00, i_weight}) + 18'(i_step);

    always_comb begin
        if (sum > $signed({2'b00, i_lim.ceiling})) begin
            o_weight = i_lim.ceiling;
        end else if (sum < $signed({2'b00, i_lim.floor})) begin
            o_weight = i_lim.floor;
        end else begin
            o_weight = sum[15:0];
        end
    end

endmodule

// ===== design/stdp_synapse_weight_updater_core.sv =====
// STDP synapse weight updater top level: sequencer, spike time stores,
// conductance memories and APB register file. Depends on stdpw_pkg, stdpw_pulse.
//
// Usage:
//   Input channel (i_valid/o_ready, i_data) takes one request beat: a spike
//   event or a read of one synapse pair. Output channel (o_valid/i_ready,
//   o_data) returns exactly one result beat per request. The user must write
//   registers over the APB port only while the block is idle (not enforced).
// Learning walk:
//   A read, or a spike that records only, needs no walk. A learning spike
//   walks neurons with 0..1 pulses each in bipolar mode and 0..2 in
//   differential mode; the walk covers HIDDEN_COUNT (visible spike) or
//   VISIBLE_COUNT (hidden spike) neurons, one read-modify-write of the shared
//   pulse unit per pulse.
// Reset:
//   Registers take their reset values, spike flags clear, and a clearing
//   pass over the VISIBLE_COUNT*HIDDEN_COUNT addresses (4096 by default)
//   zeroes both conductance memories; o_ready stays low during the pass.
// Stall:
//   The result sits in an output register; the next request is accepted
//   while it waits. A finished request holds until that register frees.
module stdp_synapse_weight_updater_core #(
    parameter int VISIBLE_COUNT = 64,
    parameter int HIDDEN_COUNT  = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  stdpw_pkg::t_in_beat   i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output stdpw_pkg::t_out_beat  o_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int VIW    = (VISIBLE_COUNT > 1) ? $clog2(VISIBLE_COUNT) : 1;
    localparam int HIW    = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
    localparam int NMAX   = (VISIBLE_COUNT > HIDDEN_COUNT) ? VISIBLE_COUNT : HIDDEN_COUNT;
    localparam int CW     = $clog2(NMAX + 1);
    localparam int WDEPTH = VISIBLE_COUNT * HIDDEN_COUNT;
    localparam int AW     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

    // registers
    logic               r_learn_mode;
    logic signed [16:0] r_set_step;
    logic signed [16:0] r_reset_step;
    logic [15:0]        r_ceil;
    logic [15:0]        r_floor;
    logic [15:0]        r_set_win;
    logic [15:0]        r_reset_win;
    logic [15:0]        r_stdp_win;

    stdpw_pkg::t_state    r_state, n_state;
    stdpw_pkg::t_in_beat  r_in;
    stdpw_pkg::t_out_beat r_out;
    logic                 r_out_valid;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [AW-1:0]        r_addr, n_addr;
    logic [AW-1:0]        r_stride;
    logic [7:0]           r_count, n_count;
    logic                 r_do_m;
    logic signed [16:0]   r_step_p, r_step_m;

    logic [31:0] vis_time [VISIBLE_COUNT];
    logic [31:0] hid_time [HIDDEN_COUNT];
    logic [VISIBLE_COUNT-1:0] r_vis_spk;
    logic [HIDDEN_COUNT-1:0]  r_hid_spk;
    logic [31:0] r_vis_tq, r_hid_tq;
    logic        r_vis_sq, r_hid_sq;

    logic [15:0] plus_mem  [WDEPTH];
    logic [15:0] minus_mem [WDEPTH];
    logic [15:0] r_plus_q, r_minus_q;

    logic        accept, cfg_wr, out_load;
    logic        plus_we, minus_we;
    logic [15:0] plus_wd, minus_wd;
    logic        vis_twe, hid_twe;
    logic [VIW-1:0] idx_v, cnt_v;
    logic [HIW-1:0] idx_h, cnt_h;
    logic        rd_ok, spk_ok, last;
    logic [AW-1:0] acc_row;

    logic signed [33:0] dd, sw_s, rw_s, stdp_s, swrw;
    logic        oth_spk, ge0, lt_sw, lt_rw, ge_swrw, bip_hit;
    logic        do_p, do_m;
    logic signed [16:0] step_p, step_m;

    logic [15:0]        pu_w, pu_out;
    logic signed [16:0] pu_step;
    stdpw_pkg::t_limits lim;

    stdpw_pkg::t_out_beat res;

    assign o_ready = (r_state == stdpw_pkg::S_IDLE);
    assign accept  = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    assign idx_v = VIW'(r_in.neuron_index);
    assign idx_h = HIW'(r_in.neuron_index);
    assign cnt_v = r_cnt[VIW-1:0];
    assign cnt_h = r_cnt[HIW-1:0];
    assign acc_row = AW'(AW'(i_data.neuron_index) * AW'(HIDDEN_COUNT));

    assign rd_ok = (32'(r_in.neuron_index) < VISIBLE_COUNT)
                && (32'(r_in.hidden_read_index) < HIDDEN_COUNT);
    assign spk_ok = (r_in.spike_side == stdpw_pkg::SIDE_HIDDEN)
                  ? (32'(r_in.neuron_index) < HIDDEN_COUNT)
                  : (32'(r_in.neuron_index) < VISIBLE_COUNT);
    assign last = (r_in.spike_side == stdpw_pkg::SIDE_HIDDEN)
                ? (r_cnt == CW'(VISIBLE_COUNT - 1))
                : (r_cnt == CW'(HIDDEN_COUNT - 1));

    // time window evaluation
    assign oth_spk = (r_in.spike_side == stdpw_pkg::SIDE_HIDDEN) ? r_vis_sq : r_hid_sq;
    assign dd = (r_in.spike_side == stdpw_pkg::SIDE_HIDDEN)
              ? $signed({2'b00, r_in.event_time}) - $signed({2'b00, r_vis_tq})
              : $signed({2'b00, r_in.event_time}) - $signed({2'b00, r_hid_tq});
    assign sw_s   = $signed({18'd0, r_set_win});
    assign rw_s   = $signed({18'd0, r_reset_win});
    assign stdp_s = $signed({18'd0, r_stdp_win});
    assign swrw   = sw_s - rw_s;
    assign ge0     = !dd[33];
    assign lt_sw   = dd < sw_s;
    assign lt_rw   = dd < rw_s;
    assign ge_swrw = dd >= swrw;
    assign bip_hit = (dd != 34'sd0) && (dd < stdp_s) && (dd > -stdp_s);

    always_comb begin
        do_p   = 1'b0;
        do_m   = 1'b0;
        step_p = r_set_step;
        step_m = r_reset_step;
        if (r_learn_mode == stdpw_pkg::MODE_BIPOLAR) begin
            do_p   = oth_spk && bip_hit;
            step_p = (r_in.learn_phase == stdpw_pkg::PH_DATA) ? r_set_step : r_reset_step;
        end else if (r_in.learn_phase == stdpw_pkg::PH_DATA) begin
            do_p   = oth_spk && ge0 && lt_sw;
            do_m   = oth_spk && ge0 && lt_rw;
        end else begin
            do_p   = oth_spk && ge_swrw && lt_sw;
            step_p = r_reset_step;
            do_m   = oth_spk && ge0 && lt_sw;
            step_m = r_set_step;
        end
    end

    // shared pulse unit
    assign lim.ceiling = r_ceil;
    assign lim.floor   = r_floor;
    assign pu_w    = (r_state == stdpw_pkg::S_UPD_M) ? r_minus_q : r_plus_q;
    assign pu_step = (r_state == stdpw_pkg::S_UPD_M) ? r_step_m : r_step_p;

    stdpw_pulse u_pulse (
        .i_weight (pu_w),
        .i_step   (pu_step),
        .i_lim    (lim),
        .o_weight (pu_out)
    );

    always_comb begin
        res = '0;
        res.updated_count = r_count;
        if (r_in.req_type == stdpw_pkg::REQ_READ && rd_ok) begin
            res.plus_weight  = r_plus_q;
            res.minus_weight = r_minus_q;
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_addr   = r_addr;
        n_count  = r_count;
        plus_we  = 1'b0;
        minus_we = 1'b0;
        plus_wd  = pu_out;
        minus_wd = pu_out;
        vis_twe  = 1'b0;
        hid_twe  = 1'b0;
        out_load = 1'b0;
        case (r_state)
            stdpw_pkg::S_CLEAR: begin
                plus_we  = 1'b1;
                minus_we = 1'b1;
                plus_wd  = '0;
                minus_wd = '0;
                n_addr   = r_addr + AW'(1);
                if (r_addr == AW'(WDEPTH - 1)) begin
                    n_state = stdpw_pkg::S_IDLE;
                end
            end
            stdpw_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = stdpw_pkg::S_START;
                    n_count = '0;
                    n_cnt   = '0;
                    if (i_data.req_type == stdpw_pkg::REQ_READ) begin
                        n_addr = acc_row + AW'(i_data.hidden_read_index);
                    end else if (i_data.spike_side == stdpw_pkg::SIDE_HIDDEN) begin
                        n_addr = AW'(i_data.neuron_index);
                    end else begin
                        n_addr = acc_row;
                    end
                end
            end
            stdpw_pkg::S_START: begin
                n_state = stdpw_pkg::S_DONE;
                if (r_in.req_type == stdpw_pkg::REQ_SPIKE && spk_ok) begin
                    vis_twe = (r_in.spike_side == stdpw_pkg::SIDE_VISIBLE);
                    hid_twe = (r_in.spike_side == stdpw_pkg::SIDE_HIDDEN);
                    if (!r_in.learn_phase[1]
                        && !(r_learn_mode == stdpw_pkg::MODE_DIFF
                             && r_in.spike_side == stdpw_pkg::SIDE_VISIBLE)) begin
                        n_state = stdpw_pkg::S_FETCH;
                    end
                end
            end
            stdpw_pkg::S_FETCH: begin
                n_state = stdpw_pkg::S_EVAL;
            end
            stdpw_pkg::S_EVAL: begin
                if (do_p) begin
                    n_state = stdpw_pkg::S_UPD_P;
                end else if (do_m) begin
                    n_state = stdpw_pkg::S_UPD_M;
                end else if (last) begin
                    n_state = stdpw_pkg::S_DONE;
                end else begin
                    n_state = stdpw_pkg::S_FETCH;
                    n_cnt   = r_cnt + CW'(1);
                    n_addr  = r_addr + r_stride;
                end
            end
            stdpw_pkg::S_UPD_P: begin
                plus_we = 1'b1;
                n_count = (r_count != 8'hFF) ? r_count + 8'd1 : r_count;
                if (r_do_m) begin
                    n_state = stdpw_pkg::S_UPD_M;
                end else if (last) begin
                    n_state = stdpw_pkg::S_DONE;
                end else begin
                    n_state = stdpw_pkg::S_FETCH;
                    n_cnt   = r_cnt + CW'(1);
                    n_addr  = r_addr + r_stride;
                end
            end
            stdpw_pkg::S_UPD_M: begin
                minus_we = 1'b1;
                n_count  = (r_count != 8'hFF) ? r_count + 8'd1 : r_count;
                if (last) begin
                    n_state = stdpw_pkg::S_DONE;
                end else begin
                    n_state = stdpw_pkg::S_FETCH;
                    n_cnt   = r_cnt + CW'(1);
                    n_addr  = r_addr + r_stride;
                end
            end
            stdpw_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = stdpw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stdpw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stdpw_pkg::S_CLEAR;
            r_addr      <= '0;
            r_cnt       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_vis_spk   <= '0;
            r_hid_spk   <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_cnt   <= n_cnt;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (vis_twe) begin
                r_vis_spk[idx_v] <= 1'b1;
            end
            if (hid_twe) begin
                r_hid_spk[idx_h] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in     <= i_data;
            r_stride <= (i_data.spike_side == stdpw_pkg::SIDE_HIDDEN)
                      ? AW'(HIDDEN_COUNT) : AW'(1);
        end
        if (out_load) begin
            r_out <= res;
        end
        if (r_state == stdpw_pkg::S_EVAL) begin
            r_do_m   <= do_m;
            r_step_p <= step_p;
            r_step_m <= step_m;
        end
        r_vis_sq <= r_vis_spk[cnt_v];
        r_hid_sq <= r_hid_spk[cnt_h];
    end

    // spike time stores
    always_ff @(posedge i_clk) begin
        if (vis_twe) begin
            vis_time[idx_v] <= r_in.event_time;
        end
        r_vis_tq <= vis_time[cnt_v];
    end

    always_ff @(posedge i_clk) begin
        if (hid_twe) begin
            hid_time[idx_h] <= r_in.event_time;
        end
        r_hid_tq <= hid_time[cnt_h];
    end

    // conductance memories
    always_ff @(posedge i_clk) begin
        if (plus_we) begin
            plus_mem[r_addr] <= plus_wd;
        end
        r_plus_q <= plus_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (minus_we) begin
            minus_mem[r_addr] <= minus_wd;
        end
        r_minus_q <= minus_mem[r_addr];
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_mode <= stdpw_pkg::MODE_DIFF;
            r_set_step   <= 17'sd256;
            r_reset_step <= -17'sd65535;
            r_ceil       <= 16'hFFFF;
            r_floor      <= 16'd0;
            r_set_win    <= 16'd100;
            r_reset_win  <= 16'd50;
            r_stdp_win   <= 16'd100;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                stdpw_pkg::REG_LEARN_MODE:     r_learn_mode <= pwdata[0];
                stdpw_pkg::REG_SET_STEP:       r_set_step   <= $signed(pwdata[16:0]);
                stdpw_pkg::REG_RESET_STEP:     r_reset_step <= $signed(pwdata[16:0]);
                stdpw_pkg::REG_WEIGHT_CEILING: r_ceil       <= pwdata[15:0];
                stdpw_pkg::REG_WEIGHT_FLOOR:   r_floor      <= pwdata[15:0];
                stdpw_pkg::REG_SET_WINDOW:     r_set_win    <= pwdata[15:0];
                stdpw_pkg::REG_RESET_WINDOW:   r_reset_win  <= pwdata[15:0];
                stdpw_pkg::REG_STDP_WINDOW:    r_stdp_win   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            stdpw_pkg::REG_LEARN_MODE:     prdata = {31'd0, r_learn_mode};
            stdpw_pkg::REG_SET_STEP:       prdata = {15'd0, r_set_step};
            stdpw_pkg::REG_RESET_STEP:     prdata = {15'd0, r_reset_step};
            stdpw_pkg::REG_WEIGHT_CEILING: prdata = {16'd0, r_ceil};
            stdpw_pkg::REG_WEIGHT_FLOOR:   prdata = {16'd0, r_floor};
            stdpw_pkg::REG_SET_WINDOW:     prdata = {16'd0, r_set_win};
            stdpw_pkg::REG_RESET_WINDOW:   prdata = {16'd0, r_reset_win};
            stdpw_pkg::REG_STDP_WINDOW:    prdata = {16'd0, r_stdp_win};
            default:                       prdata = '0;
        endcase
    end

    // checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("ready high right after an accepted beat");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stdpw_pkg::S_IDLE || r_state == stdpw_pkg::S_DONE)
        |-> !plus_we && !minus_we)
        else $error("conductance write outside a walk");

    a_count_after_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stdpw_pkg::S_UPD_P || r_state == stdpw_pkg::S_UPD_M)
        |=> r_count != 8'd0)
        else $error("pulse not counted");

    a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stdpw_pkg::S_UPD_P && r_ceil >= r_floor)
        |-> plus_wd <= r_ceil && plus_wd >= r_floor)
        else $error("plus conductance outside limits");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stdpw_pkg::S_FETCH) |-> r_cnt < CW'(NMAX))
        else $error("walk counter past last neuron");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for stdp_synapse_weight_updater_core: a directed table and
// paced random spike/read beats, checked against typed rows or a behavioral predictor.
// Depends on stdpw_pkg and the core RTL.
module tb_top;

    localparam int NV             = 64;
    localparam int NH             = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 800;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 300;
    localparam int RANDOM_ROUNDS  = 9;
    localparam int ROUND_BEATS    = 48;

    localparam logic [1:0] PH_TRANSITION = 2'd2;
    localparam logic [1:0] PH_RESERVED   = 2'd3;

    typedef struct {
        bit                   is_cfg;
        logic [2:0]           reg_idx;
        logic [31:0]          value;
        stdpw_pkg::t_in_beat  beat;
        bit                   typed;
        stdpw_pkg::t_out_beat result;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    stdpw_pkg::t_in_beat  i_data;
    logic                 o_valid;
    logic                 i_ready;
    stdpw_pkg::t_out_beat o_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [4:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    stdp_synapse_weight_updater_core #(
        .VISIBLE_COUNT (NV),
        .HIDDEN_COUNT  (NH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [31:0] vis_stamp [NV];
    bit          vis_fired [NV];
    logic [31:0] hid_stamp [NH];
    bit          hid_fired [NH];
    logic [15:0] plus_shadow [NV*NH];
    logic [15:0] minus_shadow [NV*NH];

    logic   cfg_mode;
    int     cfg_set_step;
    int     cfg_reset_step;
    int     cfg_ceiling;
    int     cfg_floor;
    longint cfg_set_win;
    longint cfg_reset_win;
    longint cfg_stdp_win;

    stdpw_pkg::t_out_beat expected_results [$];
    stdpw_pkg::t_out_beat oldest_result;
    int        error_count   = 0;
    int        quiet_cycles  = 0;
    int        burst_left    = 0;
    int        hold_requests = 0;
    int        holds_served  = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic apply_pulse(inout logic [15:0] w, input int step, inout int cnt);
        int n;
        n = int'({16'b0, w}) + step;
        if (n > cfg_ceiling) begin
            n = cfg_ceiling;
        end else if (n < cfg_floor) begin
            n = cfg_floor;
        end
        w = n[15:0];
        if (cnt < 255) cnt++;
    endtask

    task automatic predict_result(input stdpw_pkg::t_in_beat b,
                                  output stdpw_pkg::t_out_beat r);
        int     cnt;
        int     step;
        int     a;
        int     idx;
        bit     seen;
        longint tt;
        longint tv;
        longint td;
        r   = '0;
        cnt = 0;
        idx = int'(b.neuron_index);
        tt  = {32'b0, b.event_time};
        if (b.req_type == stdpw_pkg::REQ_READ) begin
            a = idx * NH + int'(b.hidden_read_index);
            r.plus_weight  = plus_shadow[a];
            r.minus_weight = minus_shadow[a];
            return;
        end
        if (b.spike_side == stdpw_pkg::SIDE_VISIBLE) begin
            vis_stamp[idx] = b.event_time;
            vis_fired[idx] = 1'b1;
        end else begin
            hid_stamp[idx] = b.event_time;
            hid_fired[idx] = 1'b1;
        end
        if (b.learn_phase != stdpw_pkg::PH_DATA && b.learn_phase != stdpw_pkg::PH_MODEL)
            return;
        if (cfg_mode == stdpw_pkg::MODE_BIPOLAR) begin
            step = (b.learn_phase == stdpw_pkg::PH_DATA) ? cfg_set_step : cfg_reset_step;
            for (int i = 0; i < 64; i++) begin
                if (b.spike_side == stdpw_pkg::SIDE_VISIBLE) begin
                    seen = hid_fired[i];
                    tv   = {32'b0, hid_stamp[i]};
                    a    = idx * NH + i;
                end else begin
                    seen = vis_fired[i];
                    tv   = {32'b0, vis_stamp[i]};
                    a    = i * NH + idx;
                end
                if (!seen) continue;
                td = tt - tv;
                if (td < 0) td = -td;
                if (td == 0 || td >= cfg_stdp_win) continue;
                apply_pulse(plus_shadow[a], step, cnt);
            end
        end else if (b.spike_side == stdpw_pkg::SIDE_HIDDEN) begin
            for (int i = 0; i < NV; i++) begin
                if (!vis_fired[i]) continue;
                tv = {32'b0, vis_stamp[i]};
                a  = i * NH + idx;
                if (b.learn_phase == stdpw_pkg::PH_DATA) begin
                    if (tt >= tv && tt < tv + cfg_set_win)
                        apply_pulse(plus_shadow[a], cfg_set_step, cnt);
                    if (tt >= tv && tt < tv + cfg_reset_win)
                        apply_pulse(minus_shadow[a], cfg_reset_step, cnt);
                end else begin
                    if (tt >= tv + cfg_set_win - cfg_reset_win && tt < tv + cfg_set_win)
                        apply_pulse(plus_shadow[a], cfg_reset_step, cnt);
                    if (tt >= tv && tt < tv + cfg_set_win)
                        apply_pulse(minus_shadow[a], cfg_set_step, cnt);
                end
            end
        end
        r.updated_count = cnt[7:0];
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            stdpw_pkg::REG_LEARN_MODE:     cfg_mode       = val[0];
            stdpw_pkg::REG_SET_STEP:       cfg_set_step   = int'($signed(val[16:0]));
            stdpw_pkg::REG_RESET_STEP:     cfg_reset_step = int'($signed(val[16:0]));
            stdpw_pkg::REG_WEIGHT_CEILING: cfg_ceiling    = int'(val[15:0]);
            stdpw_pkg::REG_WEIGHT_FLOOR:   cfg_floor      = int'(val[15:0]);
            stdpw_pkg::REG_SET_WINDOW:     cfg_set_win    = longint'(val[15:0]);
            stdpw_pkg::REG_RESET_WINDOW:   cfg_reset_win  = longint'(val[15:0]);
            stdpw_pkg::REG_STDP_WINDOW:    cfg_stdp_win   = longint'(val[15:0]);
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic mode, input int sstep, input int rstep,
                                input int ceil_v, input int floor_v, input int sw,
                                input int rw, input int sdw);
        write_reg(stdpw_pkg::REG_LEARN_MODE, {31'b0, mode});
        write_reg(stdpw_pkg::REG_SET_STEP, 32'(sstep));
        write_reg(stdpw_pkg::REG_RESET_STEP, 32'(rstep));
        write_reg(stdpw_pkg::REG_WEIGHT_CEILING, 32'(ceil_v));
        write_reg(stdpw_pkg::REG_WEIGHT_FLOOR, 32'(floor_v));
        write_reg(stdpw_pkg::REG_SET_WINDOW, 32'(sw));
        write_reg(stdpw_pkg::REG_RESET_WINDOW, 32'(rw));
        write_reg(stdpw_pkg::REG_STDP_WINDOW, 32'(sdw));
    endtask

    // drop valid and wait until every outstanding beat has come back
    task automatic settle_block();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_beat(input stdpw_pkg::t_in_beat b, input bit typed,
                             input stdpw_pkg::t_out_beat typed_result);
        stdpw_pkg::t_out_beat predicted;
        int        pick;
        int        gap;
        if (burst_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) gap = 0;
            else if (pick < 8) gap = $urandom_range(1, 4);
            else gap = $urandom_range(5, 30);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid = 1'b0;
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid = 1'b1;
        i_data  = b;
        do @(posedge i_clk); while (!o_ready);
        predict_result(b, predicted);
        expected_results.push_back(typed ? typed_result : predicted);
    endtask

    function automatic int pick_step();
        case ($urandom_range(0, 4))
            0:       return 65535;
            1:       return -65535;
            2:       return int'($urandom_range(0, 131070)) - 65535;
            default: return int'($urandom_range(0, 4000)) - 2000;
        endcase
    endfunction

    function automatic t_row cfg_row(logic [2:0] idx, logic [31:0] val);
        t_row r;
        r         = '{default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.value   = val;
        return r;
    endfunction

    function automatic t_row spike_row(logic side, logic [5:0] idx, logic [31:0] t,
                                       logic [1:0] ph, bit typed, logic [7:0] cnt);
        t_row r;
        r                      = '{default: '0};
        r.beat.req_type        = stdpw_pkg::REQ_SPIKE;
        r.beat.spike_side      = side;
        r.beat.neuron_index    = idx;
        r.beat.event_time      = t;
        r.beat.learn_phase     = ph;
        r.typed                = typed;
        r.result.updated_count = cnt;
        return r;
    endfunction

    function automatic t_row read_row(logic [5:0] v, logic [5:0] h, bit typed,
                                      logic [15:0] p, logic [15:0] m);
        t_row r;
        r                        = '{default: '0};
        r.beat.req_type          = stdpw_pkg::REQ_READ;
        r.beat.neuron_index      = v;
        r.beat.hidden_read_index = h;
        r.typed                  = typed;
        r.result.plus_weight     = p;
        r.result.minus_weight    = m;
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing outstanding: %p", o_data);
                error_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                if (o_data.updated_count !== oldest_result.updated_count) begin
                    $error("updated_count: expected %0d, got %0d",
                           oldest_result.updated_count, o_data.updated_count);
                    error_count++;
                end
                if (o_data.plus_weight !== oldest_result.plus_weight) begin
                    $error("plus_weight: expected %0d, got %0d",
                           oldest_result.plus_weight, o_data.plus_weight);
                    error_count++;
                end
                if (o_data.minus_weight !== oldest_result.minus_weight) begin
                    $error("minus_weight: expected %0d, got %0d",
                           oldest_result.minus_weight, o_data.minus_weight);
                    error_count++;
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[stdp_synapse_weight_updater_core] ERROR");
            $finish;
        end
    end

    // result sink: own stall pattern plus long hold-off on request
    initial begin
        int hold_left;
        int rx_mode;
        int mode_left;
        int rx_tick;
        hold_left = 0;
        rx_mode   = 0;
        mode_left = 0;
        rx_tick   = 0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_tick++;
            if (hold_left > 0) begin
                hold_left--;
                i_ready = 1'b0;
            end else if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES - 1;
                i_ready      = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (rx_mode)
                    0:       i_ready = 1'b1;
                    1:       i_ready = 1'($urandom_range(0, 1));
                    2:       i_ready = ($urandom_range(0, 3) == 0);
                    default: i_ready = ((rx_tick % 5) != 0);
                endcase
            end
        end
    end

    initial begin
        t_row                directed [$];
        stdpw_pkg::t_in_beat b;
        logic [31:0]         tick_now;
        logic [5:0]          last_vis;
        logic [5:0]          last_hid;
        int                  kind;
        int                  pick;

        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_data   = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        last_vis = '0;
        last_hid = '0;

        cfg_mode       = stdpw_pkg::MODE_DIFF;
        cfg_set_step   = 256;
        cfg_reset_step = -65535;
        cfg_ceiling    = 65535;
        cfg_floor      = 0;
        cfg_set_win    = 100;
        cfg_reset_win  = 50;
        cfg_stdp_win   = 100;
        for (int i = 0; i < NV; i++) begin
            vis_stamp[i] = '0;
            vis_fired[i] = 1'b0;
        end
        for (int i = 0; i < NH; i++) begin
            hid_stamp[i] = '0;
            hid_fired[i] = 1'b0;
        end
        for (int i = 0; i < NV * NH; i++) begin
            plus_shadow[i]  = '0;
            minus_shadow[i] = '0;
        end

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        // clearing pass after reset
        do @(posedge i_clk); while (!o_ready);

        // reset defaults: differential rule
        directed.push_back(read_row(6'd0, 6'd0, 1, 16'd0, 16'd0));
        directed.push_back(read_row(6'd63, 6'd63, 1, 16'd0, 16'd0));
        directed.push_back(spike_row(stdpw_pkg::SIDE_VISIBLE, 6'd0, 32'd1000,
                                     stdpw_pkg::PH_DATA, 1, 8'd0));
        directed.push_back(spike_row(stdpw_pkg::SIDE_VISIBLE, 6'd63, 32'd1010,
                                     stdpw_pkg::PH_MODEL, 1, 8'd0));
        directed.push_back(spike_row(stdpw_pkg::SIDE_HIDDEN, 6'd0, 32'd1020,
                                     stdpw_pkg::PH_DATA, 0, 8'd0));
        directed.push_back(read_row(6'd0, 6'd0, 0, 16'd0, 16'd0));
        directed.push_back(read_row(6'd63, 6'd0, 0, 16'd0, 16'd0));
        directed.push_back(spike_row(stdpw_pkg::SIDE_HIDDEN, 6'd5, 32'd1090,
                                     stdpw_pkg::PH_MODEL, 0, 8'd0));
        directed.push_back(read_row(6'd0, 6'd5, 0, 16'd0, 16'd0));
        directed.push_back(spike_row(stdpw_pkg::SIDE_HIDDEN, 6'd63, 32'hFFFF_FFFF,
                                     PH_TRANSITION, 1, 8'd0));
        directed.push_back(spike_row(stdpw_pkg::SIDE_VISIBLE, 6'd1, 32'hFFFF_FFFF,
                                     PH_RESERVED, 1, 8'd0));
        directed.push_back(spike_row(stdpw_pkg::SIDE_HIDDEN, 6'd1, 32'hFFFF_FFFF,
                                     stdpw_pkg::PH_DATA, 0, 8'd0));
        directed.push_back(read_row(6'd1, 6'd1, 0, 16'd0, 16'd0));
        // bipolar rule
        directed.push_back(cfg_row(stdpw_pkg::REG_LEARN_MODE,
                                   {31'b0, stdpw_pkg::MODE_BIPOLAR}));
        directed.push_back(spike_row(stdpw_pkg::SIDE_VISIBLE, 6'd2, 32'hFFFF_FFF0,
                                     stdpw_pkg::PH_DATA, 0, 8'd0));
        directed.push_back(spike_row(stdpw_pkg::SIDE_HIDDEN, 6'd2, 32'hFFFF_FFFF,
                                     stdpw_pkg::PH_MODEL, 0, 8'd0));
        directed.push_back(read_row(6'd2, 6'd2, 0, 16'd0, 16'd0));
        directed.push_back(cfg_row(stdpw_pkg::REG_SET_STEP, 32'd65535));
        directed.push_back(cfg_row(stdpw_pkg::REG_WEIGHT_FLOOR, 32'h1000));
        directed.push_back(cfg_row(stdpw_pkg::REG_WEIGHT_CEILING, 32'h2000));
        directed.push_back(cfg_row(stdpw_pkg::REG_STDP_WINDOW, 32'd65535));
        directed.push_back(spike_row(stdpw_pkg::SIDE_VISIBLE, 6'd3, 32'd0,
                                     stdpw_pkg::PH_DATA, 0, 8'd0));
        directed.push_back(read_row(6'd3, 6'd0, 0, 16'd0, 16'd0));
        directed.push_back(spike_row(stdpw_pkg::SIDE_HIDDEN, 6'd0, 32'd0,
                                     stdpw_pkg::PH_MODEL, 0, 8'd0));
        directed.push_back(read_row(6'd0, 6'd0, 0, 16'd0, 16'd0));

        foreach (directed[n]) begin
            if (directed[n].is_cfg) begin
                settle_block();
                write_reg(directed[n].reg_idx, directed[n].value);
            end else begin
                send_beat(directed[n].beat, directed[n].typed, directed[n].result);
            end
        end

        for (int r = 0; r < RANDOM_ROUNDS; r++) begin
            settle_block();
            case (r)
                1: apply_config(stdpw_pkg::MODE_DIFF, 65535, -65535, 65535, 0,
                                65535, 65535, 65535);
                2: apply_config(stdpw_pkg::MODE_BIPOLAR, -65535, 65535, 0, 65535,
                                0, 0, 65535);
                default: apply_config((r % 2 == 0) ? stdpw_pkg::MODE_BIPOLAR
                                                   : stdpw_pkg::MODE_DIFF,
                                      pick_step(), pick_step(),
                                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                  : $urandom_range(40000, 65535),
                                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                  : $urandom_range(0, 2000),
                                      $urandom_range(0, 300), $urandom_range(0, 300),
                                      ($urandom_range(0, 7) == 0) ? 65535
                                                                  : $urandom_range(0, 300));
            endcase
            if (r == 3) hold_requests++;
            tick_now = (r == 4) ? 32'hFFFF_FF00 : $urandom;
            for (int k = 0; k < ROUND_BEATS; k++) begin
                b    = '0;
                kind = $urandom_range(0, 99);
                if (kind < 20) begin
                    b.req_type          = stdpw_pkg::REQ_READ;
                    b.neuron_index      = $urandom_range(0, 1) ? last_vis
                                                               : 6'($urandom_range(0, 63));
                    b.hidden_read_index = $urandom_range(0, 1) ? last_hid
                                                               : 6'($urandom_range(0, 63));
                    b.event_time        = $urandom;
                    b.learn_phase       = 2'($urandom_range(0, 3));
                    b.spike_side        = 1'($urandom_range(0, 1));
                end else begin
                    b.req_type     = stdpw_pkg::REQ_SPIKE;
                    b.spike_side   = (kind < 55) ? stdpw_pkg::SIDE_VISIBLE
                                                 : stdpw_pkg::SIDE_HIDDEN;
                    b.neuron_index = 6'($urandom_range(0, 63));
                    b.hidden_read_index = 6'($urandom_range(0, 63));
                    if ($urandom_range(0, 19) == 0) begin
                        b.event_time = $urandom;
                    end else begin
                        tick_now     = tick_now + $urandom_range(0, 40);
                        b.event_time = tick_now;
                    end
                    pick = $urandom_range(0, 19);
                    if (pick < 8) b.learn_phase = stdpw_pkg::PH_DATA;
                    else if (pick < 16) b.learn_phase = stdpw_pkg::PH_MODEL;
                    else if (pick < 19) b.learn_phase = PH_TRANSITION;
                    else b.learn_phase = PH_RESERVED;
                    if (b.spike_side == stdpw_pkg::SIDE_VISIBLE) last_vis = b.neuron_index;
                    else last_hid = b.neuron_index;
                end
                send_beat(b, 0, '0);
            end
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[stdp_synapse_weight_updater_core] OK");
        end else begin
            $display("[stdp_synapse_weight_updater_core] ERROR");
        end
        $finish;
    end

endmodule
